FILE: rtl/wbps_pkg.sv
// package: widths, register indexes and pattern lookup helpers for the byte pattern scanner
`timescale 1ns / 1ps
package wbps_pkg;

	localparam int PATTERN_MAX_DEF = 16;
	localparam int OFFSET_BITS_DEF = 32;
	localparam int CFG_IDX_W = 8;
	localparam int CFG_DATA_W = 64;
	localparam int MATCH_OFS_W = 32;
	localparam int MASK_W = 16;
	localparam int LEN_CFG_W = 5;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PAT_LO = 8'd0,
		REG_PAT_HI = 8'd1,
		REG_WILD   = 8'd2,
		REG_LEN    = 8'd3
	} cfg_reg_t;

	// pattern byte at a position; positions past the registers read as zero
	function automatic logic [7:0] pat_byte_at(input logic [63:0] lo, input logic [63:0] hi,
		input logic [7:0] pos);
		logic [7:0] r;
		r = 8'd0;
		if (pos < 8'd8) begin
			r = lo[pos[2:0]*8 +: 8];
		end else if (pos < 8'd16) begin
			r = hi[pos[2:0]*8 +: 8];
		end
		return r;
	endfunction

	// positions past the mask are never wildcards
	function automatic logic wild_at(input logic [MASK_W-1:0] mask, input logic [7:0] pos);
		logic r;
		r = 1'b0;
		if (pos < 8'(MASK_W)) begin
			r = mask[pos[3:0]];
		end
		return r;
	endfunction

endpackage

FILE: rtl/wbps_if.sv
// stream interfaces: region byte input, scan result output, register write port
`timescale 1ns / 1ps
interface wbps_byte_if import wbps_pkg::*; ();
	logic       valid;
	logic       ready;
	logic [7:0] region_byte;
	logic       last_byte;
	modport source (output valid, output region_byte, output last_byte, input ready);
	modport sink (input valid, input region_byte, input last_byte, output ready);
endinterface

interface wbps_result_if import wbps_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic                   found;
	logic [MATCH_OFS_W-1:0] match_offset;
	modport source (output valid, output found, output match_offset, input ready);
	modport sink (input valid, input found, input match_offset, output ready);
endinterface

interface wbps_cfg_if import wbps_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

FILE: rtl/wbps_cell.sv
// window cell: holds a window byte, compares its next byte with its aligned pattern byte
`timescale 1ns / 1ps
module wbps_cell import wbps_pkg::*; (
	input  logic       clk,
	input  logic       shift_en,
	input  logic [7:0] byte_d,
	input  logic [7:0] pat_byte,
	input  logic       wild,
	input  logic       use_pos,
	output logic [7:0] win_q,
	output logic       pos_ok
);

	always_ff @(posedge clk) begin
		if (shift_en) begin
			win_q <= byte_d;
		end
	end

	// compare against the byte this cell takes on the current beat
	assign pos_ok = !use_pos || wild || (pat_byte == byte_d);

endmodule

FILE: rtl/wildcard_byte_pattern_scan_top.sv
// wildcard byte pattern scanner: the result shows in the cycle after its byte beat
// one byte per cycle unless stalled; the window shifts through a chain of byte cells
// and all aligned positions are compared in parallel in the beat's cycle
// a result waits in an output register; bytes stall only while it waits unread
// arst_n clears config, result valid, byte count and reported flag; no clearing pass
`timescale 1ns / 1ps
module wildcard_byte_pattern_scan_top import wbps_pkg::*; #(
	parameter int PATTERN_MAX = PATTERN_MAX_DEF,
	parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
	input logic       clk,
	input logic       arst_n,
	wbps_byte_if.sink byte_in,
	wbps_result_if.source result,
	wbps_cfg_if.sink  cfg
);

	localparam int LW = $clog2(PATTERN_MAX + 1);
	localparam int CMW = (LW > LEN_CFG_W) ? LW : LEN_CFG_W;

	logic [63:0]           pat_lo_q;
	logic [63:0]           pat_hi_q;
	logic [MASK_W-1:0]     wild_q;
	logic [LEN_CFG_W-1:0]  len_q;
	logic [OFFSET_BITS-1:0] cnt_q;
	logic                  reported_q;
	logic                  res_valid_q;
	logic                  res_found_q;
	logic [MATCH_OFS_W-1:0] res_ofs_q;

	logic [CMW-1:0]        len_ext;
	logic [LW-1:0]         len_eff;
	logic [OFFSET_BITS-1:0] cnt_next;
	logic [OFFSET_BITS-1:0] len_cnt;
	logic [OFFSET_BITS-1:0] ofs_full;
	logic [OFFSET_BITS+MATCH_OFS_W-1:0] ofs_wide;
	logic                  accept;
	logic                  hit;
	logic                  emit;
	logic [7:0]            chain_d [PATTERN_MAX];
	logic [7:0]            win [PATTERN_MAX];
	logic [PATTERN_MAX-1:0] pos_ok;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_lo_q <= '0;
			pat_hi_q <= '0;
			wild_q <= '0;
			len_q <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_PAT_LO: pat_lo_q <= cfg.data;
				REG_PAT_HI: pat_hi_q <= cfg.data;
				REG_WILD:   wild_q <= cfg.data[MASK_W-1:0];
				REG_LEN:    len_q <= cfg.data[LEN_CFG_W-1:0];
				default: ;
			endcase
		end
	end

	// length clamped to the window depth
	always_comb begin
		len_ext = CMW'(len_q);
		if (len_ext > CMW'(PATTERN_MAX)) begin
			len_eff = LW'(PATTERN_MAX);
		end else begin
			len_eff = len_ext[LW-1:0];
		end
	end

	assign accept = byte_in.valid && byte_in.ready;
	assign byte_in.ready = !res_valid_q || result.ready;

	genvar k;
	generate
		for (k = 0; k < PATTERN_MAX; k++) begin : g_cell
			logic [7:0] pos;
			logic       use_pos;
			assign pos = 8'(len_eff) - 8'd1 - 8'(k);
			assign use_pos = 8'(k) < 8'(len_eff);
			if (k == 0) begin : g_head
				assign chain_d[k] = byte_in.region_byte;
			end else begin : g_link
				assign chain_d[k] = win[k-1];
			end
			wbps_cell u_cell (
				.clk      (clk),
				.shift_en (accept),
				.byte_d   (chain_d[k]),
				.pat_byte (pat_byte_at(pat_lo_q, pat_hi_q, pos)),
				.wild     (wild_at(wild_q, pos)),
				.use_pos  (use_pos),
				.win_q    (win[k]),
				.pos_ok   (pos_ok[k])
			);
		end
	endgenerate

	assign cnt_next = (&cnt_q) ? cnt_q : cnt_q + 1'b1;
	assign len_cnt = OFFSET_BITS'(len_eff);
	assign ofs_full = cnt_next - len_cnt;
	assign ofs_wide = {{MATCH_OFS_W{1'b0}}, ofs_full};
	assign hit = !reported_q && (len_eff != '0) && (cnt_next >= len_cnt) && (&pos_ok);
	assign emit = hit || (byte_in.last_byte && !reported_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			reported_q <= 1'b0;
		end else if (accept) begin
			if (byte_in.last_byte) begin
				cnt_q <= '0;
				reported_q <= 1'b0;
			end else begin
				cnt_q <= cnt_next;
				if (hit) begin
					reported_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (accept) begin
			res_valid_q <= emit;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && emit) begin
			res_found_q <= hit;
			res_ofs_q <= hit ? ofs_wide[MATCH_OFS_W-1:0] : '0;
		end
	end

	assign result.valid = res_valid_q;
	assign result.found = res_found_q;
	assign result.match_offset = res_ofs_q;

`ifndef SYNTHESIS
	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && byte_in.last_byte |=> cnt_q == '0 && !reported_q)
		else $error("state not cleared after last byte");
	a_hit_marks: assert property (@(posedge clk) disable iff (!arst_n)
		accept && hit && !byte_in.last_byte |=> reported_q && res_valid_q && res_found_q)
		else $error("match not recorded");
	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		!byte_in.ready |-> res_valid_q)
		else $error("input stalled with empty output register");
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && !res_found_q |-> res_ofs_q == '0)
		else $error("not-found result with nonzero offset");
`endif

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps
// testbench for the wildcard byte pattern scanner: directed and random regions against a predictor
module tb;
	import wbps_pkg::*;

	typedef struct packed {
		logic                   found;
		logic [MATCH_OFS_W-1:0] offset;
	} scan_result_t;

	localparam int ITEM_TARGET = 900;
	localparam int CALM_FROM = 760;
	localparam int STALL_LIMIT = 500;

	logic clk;
	logic arst_n;

	wbps_byte_if   byte_bus ();
	wbps_result_if res_bus ();
	wbps_cfg_if    cfg_bus ();

	wildcard_byte_pattern_scan_top i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.byte_in(byte_bus),
		.result(res_bus),
		.cfg(cfg_bus)
	);

	// shadow registers
	logic [63:0]          pat_lo;
	logic [63:0]          pat_hi;
	logic [MASK_W-1:0]    wild_mask;
	logic [LEN_CFG_W-1:0] pat_len;

	// shadow scan state
	logic [7:0]                 window [PATTERN_MAX_DEF];
	logic [OFFSET_BITS_DEF-1:0] seen_cnt;
	bit                         reported;

	scan_result_t expected_scans[$];
	bit idling;
	int errors = 0;
	int bytes_sent = 0;
	int regions_sent = 0;
	int found_cnt = 0;
	int miss_cnt = 0;
	int settings_cnt = 0;
	int stall_cycles = 0;

	initial clk = 1'b0;
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic int active_len();
		int len;
		len = int'(pat_len);
		if (len > PATTERN_MAX_DEF) begin
			len = PATTERN_MAX_DEF;
		end
		return len;
	endfunction

	function automatic logic [7:0] pattern_at(input int pos);
		logic [7:0] r;
		if (pos < 8) begin
			r = pat_lo[pos*8 +: 8];
		end else begin
			r = pat_hi[(pos-8)*8 +: 8];
		end
		return r;
	endfunction

	function automatic logic [7:0] alphabet_byte();
		logic [7:0] r;
		case ($urandom_range(0, 3))
			0: r = 8'h00;
			1: r = 8'hFF;
			2: r = 8'h41;
			default: r = 8'h42;
		endcase
		return r;
	endfunction

	function automatic void clear_scan();
		int k;
		for (k = 0; k < PATTERN_MAX_DEF; k++) begin
			window[k] = 8'h00;
		end
		seen_cnt = '0;
		reported = 1'b0;
	endfunction

	// shift the byte in, compare the newest len bytes, queue any result
	function automatic void scan_step(input logic [7:0] b, input logic last);
		int len;
		int k;
		int i;
		bit hit;
		scan_result_t r;
		len = active_len();
		for (k = PATTERN_MAX_DEF - 1; k > 0; k--) begin
			window[k] = window[k-1];
		end
		window[0] = b;
		if (seen_cnt != '1) begin
			seen_cnt = seen_cnt + 1'b1;
		end
		if (!reported && len > 0 && seen_cnt >= len) begin
			hit = 1'b1;
			for (i = 0; i < len; i++) begin
				if (!wild_mask[i] && pattern_at(i) != window[len-1-i]) begin
					hit = 1'b0;
				end
			end
			if (hit) begin
				reported = 1'b1;
				r.found = 1'b1;
				r.offset = MATCH_OFS_W'(seen_cnt - len);
				expected_scans.push_back(r);
				found_cnt++;
			end
		end
		if (last) begin
			if (!reported) begin
				r = '0;
				expected_scans.push_back(r);
				miss_cnt++;
			end
			clear_scan();
		end
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic last);
		if (idling && $urandom_range(0, 5) == 0) begin
			byte_bus.valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		byte_bus.valid <= 1'b1;
		byte_bus.region_byte <= b;
		byte_bus.last_byte <= last;
		do @(posedge clk); while (!byte_bus.ready);
		scan_step(b, last);
		bytes_sent++;
		if (last) begin
			regions_sent++;
		end
	endtask

	// drop valid and let all results drain
	task automatic settle();
		byte_bus.valid <= 1'b0;
		while (expected_scans.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [63:0] val);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data <= val;
		do @(posedge clk); while (!cfg_bus.ready);
		case (idx)
			REG_PAT_LO: pat_lo = val;
			REG_PAT_HI: pat_hi = val;
			REG_WILD: wild_mask = val[MASK_W-1:0];
			REG_LEN: pat_len = val[LEN_CFG_W-1:0];
			default: ;
		endcase
	endtask

	task automatic program_pattern(input logic [63:0] lo, input logic [63:0] hi,
		input logic [63:0] mask_word, input logic [63:0] len_word);
		settle();
		write_reg(REG_PAT_LO, lo);
		write_reg(REG_PAT_HI, hi);
		write_reg(REG_WILD, mask_word);
		write_reg(REG_LEN, len_word);
		cfg_bus.valid <= 1'b0;
		settings_cnt++;
	endtask

	task automatic random_setting();
		logic [63:0] lo;
		logic [63:0] hi;
		logic [63:0] mask_word;
		logic [63:0] len_word;
		int pick;
		int k;
		lo = {$urandom, $urandom};
		hi = {$urandom, $urandom};
		if ($urandom_range(0, 1) == 1) begin
			for (k = 0; k < 8; k++) begin
				lo[k*8 +: 8] = alphabet_byte();
				hi[k*8 +: 8] = alphabet_byte();
			end
		end
		len_word = {$urandom, $urandom};
		pick = $urandom_range(0, 19);
		if (pick < 2) begin
			len_word[4:0] = 5'd0;
		end else if (pick < 12) begin
			len_word[4:0] = 5'($urandom_range(1, 6));
		end else if (pick < 16) begin
			len_word[4:0] = 5'($urandom_range(7, 16));
		end else if (pick < 18) begin
			len_word[4:0] = 5'($urandom_range(17, 31));
		end else begin
			len_word[4:0] = 5'd16;
		end
		mask_word = {$urandom, $urandom};
		pick = $urandom_range(0, 19);
		if (pick < 8) begin
			mask_word[15:0] = 16'h0000;
		end else if (pick < 14) begin
			mask_word[15:0] = 16'($urandom & $urandom);
		end else if (pick >= 17) begin
			mask_word[15:0] = 16'hFFFF;
		end
		program_pattern(lo, hi, mask_word, len_word);
	endtask

	// mostly regions with the pattern planted, some near misses, some noise
	task automatic random_region();
		logic [7:0] bytes_q[$];
		int rlen;
		int len;
		int pos;
		int mode;
		int flip;
		int i;
		len = active_len();
		if ($urandom_range(0, 9) == 0) begin
			rlen = $urandom_range(17, 48);
		end else begin
			rlen = $urandom_range(1, 20);
		end
		mode = $urandom_range(0, 19);
		for (i = 0; i < rlen; i++) begin
			if ($urandom_range(0, 1) == 1) begin
				bytes_q.push_back(alphabet_byte());
			end else begin
				bytes_q.push_back(8'($urandom));
			end
		end
		if (mode < 15 && len > 0 && rlen >= len) begin
			pos = $urandom_range(0, rlen - len);
			for (i = 0; i < len; i++) begin
				if (!wild_mask[i]) begin
					bytes_q[pos+i] = pattern_at(i);
				end
			end
			if (mode >= 12) begin
				flip = $urandom_range(0, len - 1);
				bytes_q[pos+flip] = bytes_q[pos+flip] ^ (8'd1 << $urandom_range(0, 7));
			end
		end
		for (i = 0; i < rlen; i++) begin
			send_byte(bytes_q[i], i == rlen - 1);
		end
	endtask

	// registers still at reset: zero length never matches
	task automatic test_zero_length();
		send_byte(8'h00, 1'b1);
	endtask

	// pattern 00 ff with a wildcard third byte; bytes after the match give nothing
	task automatic test_exact_match();
		program_pattern(64'h0000_0000_005A_FF00, 64'hFFFF_FFFF_FFFF_FFFF,
			64'h0000_0000_0000_0004, 64'h0000_0000_0000_0003);
		send_byte(8'h11, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h7E, 1'b0);
		send_byte(8'h22, 1'b1);
	endtask

	// region shorter than the pattern ends not found
	task automatic test_short_region();
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b1);
	endtask

	task automatic test_all_wildcard();
		program_pattern(64'hDEAD_BEEF_0123_4567, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h2);
		send_byte(8'hA5, 1'b0);
		send_byte(8'h5A, 1'b0);
		send_byte(8'hC3, 1'b1);
	endtask

	// length 31 is clamped to the full 16 byte window
	task automatic test_full_length();
		int i;
		program_pattern(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
			64'hFFFF_FFFF_FFFF_0000, 64'h0000_0000_0000_001F);
		for (i = 0; i < PATTERN_MAX_DEF; i++) begin
			send_byte(8'hFF, i == PATTERN_MAX_DEF - 1);
		end
	endtask

	task automatic test_random_regions();
		while (bytes_sent < ITEM_TARGET) begin
			if (bytes_sent > CALM_FROM) begin
				idling = 1'b0;
			end
			random_setting();
			repeat ($urandom_range(1, 6)) random_region();
		end
	endtask

	// result sink with random stall bursts
	initial begin
		int stall;
		stall = 0;
		res_bus.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (stall > 0) begin
				stall--;
				res_bus.ready <= 1'b0;
			end else if (idling && $urandom_range(0, 7) == 0) begin
				stall = $urandom_range(1, 14) - 1;
				res_bus.ready <= 1'b0;
			end else begin
				res_bus.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		scan_result_t want;
		if (arst_n && res_bus.valid && res_bus.ready) begin
			if (expected_scans.size() == 0) begin
				errors++;
				$display("%0t: result beat with nothing expected, found=%0d offset=%0d",
					$time, res_bus.found, res_bus.match_offset);
			end else begin
				want = expected_scans.pop_front();
				if (res_bus.found !== want.found) begin
					errors++;
					$display("%0t: found expected %0d actual %0d",
						$time, want.found, res_bus.found);
				end
				if (res_bus.match_offset !== want.offset) begin
					errors++;
					$display("%0t: match_offset expected %0d actual %0d",
						$time, want.offset, res_bus.match_offset);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((byte_bus.valid && byte_bus.ready) || (res_bus.valid && res_bus.ready)
			|| (cfg_bus.valid && cfg_bus.ready)) begin
			stall_cycles = 0;
		end else begin
			stall_cycles++;
		end
		if (stall_cycles >= STALL_LIMIT) begin
			$display("%0t: no beat for %0d cycles, %0d results outstanding",
				$time, stall_cycles, expected_scans.size());
			$display("tb NOT OK");
			$finish;
		end
	end

	initial begin
		arst_n <= 1'b0;
		byte_bus.valid <= 1'b0;
		byte_bus.region_byte <= 8'h00;
		byte_bus.last_byte <= 1'b0;
		cfg_bus.valid <= 1'b0;
		cfg_bus.index <= REG_PAT_LO;
		cfg_bus.data <= '0;
		idling = 1'b1;
		pat_lo = '0;
		pat_hi = '0;
		wild_mask = '0;
		pat_len = '0;
		clear_scan();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		test_zero_length();
		test_exact_match();
		test_short_region();
		test_all_wildcard();
		test_full_length();
		test_random_regions();
		settle();
		$display("covered %0d bytes in %0d regions over %0d register settings",
			bytes_sent, regions_sent, settings_cnt);
		$display("results: %0d matches, %0d regions without a match", found_cnt, miss_cnt);
		if (errors == 0) begin
			$display("tb OK");
		end else begin
			$display("tb NOT OK");
		end
		$finish;
	end

endmodule
